[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("segment tracker assertion failed");
`define SRT_ASSERT_NEVER(label, clk, rst_n, expr) \
	`SRT_ASSERT(label, clk, rst_n, !(expr))
`else
`define SRT_ASSERT(label, clk, rst_n, prop)
`define SRT_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[rtl/srt_pkg.sv]
// ---------------------------------------------------------------------------
// Segment reassembly tracker package
// Verdict codes, register indexes, sweep states and shared types.
// ---------------------------------------------------------------------------
package srt_pkg;

	typedef enum logic [2:0] {
		VERDICT_ACCEPT   = 3'd0,
		VERDICT_SHORT    = 3'd1,
		VERDICT_LENGTH   = 3'd2,
		VERDICT_INDEX    = 3'd3,
		VERDICT_COUNT    = 3'd4,
		VERDICT_DUP      = 3'd5,
		VERDICT_OVERFLOW = 3'd6
	} verdict_t;

	typedef enum logic {
		CLR_RUN   = 1'b0,
		CLR_SWEEP = 1'b1
	} clr_state_t;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_PER_SEGMENT = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAME_BYTES     = 8'd1;

	localparam logic [15:0] PAYLOAD_PER_SEGMENT_RESET = 16'd1400;
	localparam logic [23:0] MAX_FRAME_BYTES_RESET     = 24'd1048576;

	// Each map entry holds the frame epoch that last set it.
	localparam int EPOCH_W = 16;
	localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 16'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	typedef struct packed {
		logic [63:0] stamp;
		logic [15:0] payload;
		verdict_t    pre;
	} front_t;

endpackage

[rtl/srt_if.sv]
// ---------------------------------------------------------------------------
// Segment reassembly tracker channels
// Header input, result output and configuration write channels.
// ---------------------------------------------------------------------------
interface srt_hdr_if;
	logic        valid;
	logic        ready;
	logic [63:0] frame_stamp;
	logic [31:0] segment_index;
	logic [31:0] segment_total;
	logic [31:0] payload_bytes;
	logic [15:0] datagram_bytes;

	modport source (output valid, frame_stamp, segment_index, segment_total,
		payload_bytes, datagram_bytes, input ready);
	modport sink (input valid, frame_stamp, segment_index, segment_total,
		payload_bytes, datagram_bytes, output ready);
endinterface

interface srt_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [23:0] write_offset;
	logic        frame_complete;
	logic [23:0] frame_length;
	logic [63:0] completed_stamp;

	modport source (output valid, verdict, write_offset, frame_complete,
		frame_length, completed_stamp, input ready);
	modport sink (input valid, verdict, write_offset, frame_complete,
		frame_length, completed_stamp, output ready);
endinterface

interface srt_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [srt_pkg::CFG_INDEX_W-1:0]    index;
	logic [srt_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/srt_map_mem.sv]
// ---------------------------------------------------------------------------
// Segment map memory
// One write port and one registered read port; holds a frame epoch per entry.
// ---------------------------------------------------------------------------
module srt_map_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/srt_front.sv]
// ---------------------------------------------------------------------------
// Segment tracker front end
// Header sanity checks and segment offset product, registered into stage 1.
// ---------------------------------------------------------------------------
module srt_front #(
	parameter int MAX_SEGMENTS = 1024,
	parameter int HEADER_BYTES = 20,
	parameter int IW           = 10,
	parameter int CW           = 11,
	parameter int OW           = 26
) (
	input  logic                clk,
	input  logic                load,
	input  logic [63:0]         frame_stamp,
	input  logic [31:0]         segment_index,
	input  logic [31:0]         segment_total,
	input  logic [31:0]         payload_bytes,
	input  logic [15:0]         datagram_bytes,
	input  logic [15:0]         payload_per_segment,
	output srt_pkg::front_t     front_s1,
	output logic [IW-1:0]       idx_s1,
	output logic [CW-1:0]       total_s1,
	output logic [OW-1:0]       offset_s1
);

	srt_pkg::verdict_t pre;
	logic [32:0]       claimed;
	logic [OW-1:0]     offset;

	assign claimed = {1'b0, payload_bytes} + 33'(HEADER_BYTES);

	// Checks in priority order; later checks only matter if earlier ones pass.
	always_comb begin
		if (datagram_bytes < 16'(HEADER_BYTES)) begin
			pre = srt_pkg::VERDICT_SHORT;
		end else if (claimed != {17'd0, datagram_bytes}) begin
			pre = srt_pkg::VERDICT_LENGTH;
		end else if (segment_index >= 32'(MAX_SEGMENTS)) begin
			pre = srt_pkg::VERDICT_INDEX;
		end else if (segment_total > 32'(MAX_SEGMENTS)) begin
			pre = srt_pkg::VERDICT_COUNT;
		end else begin
			pre = srt_pkg::VERDICT_ACCEPT;
		end
	end

	assign offset = OW'(segment_index[IW-1:0]) * OW'(payload_per_segment);

	always_ff @(posedge clk) begin
		if (load) begin
			front_s1.stamp   <= frame_stamp;
			front_s1.payload <= payload_bytes[15:0];
			front_s1.pre     <= pre;
			idx_s1           <= segment_index[IW-1:0];
			total_s1         <= segment_total[CW-1:0];
			offset_s1        <= offset;
		end
	end

endmodule

[rtl/segment_reassembly_tracker_core.sv]
// ---------------------------------------------------------------------------
// Segment reassembly tracker core
// Judges received datagram headers against the frame being rebuilt.
// ---------------------------------------------------------------------------
// hdr carries one parsed datagram header per beat; res returns one verdict
// beat per header, in order, with the payload write offset, the completion
// flag and the latched frame length and timestamp. cfg writes
// payload_per_segment (index 0) and max_frame_bytes (index 1) and is always
// ready; write it only while no header is in flight.
// A header is checked and multiplied on the beat that accepts it, decided in
// stage 1 against the segment map memory and loaded into the output register
// once res can take it. One header is taken per cycle unless res stalls or
// a sweep runs; the map's single read and single write port set that rate,
// with a forward path for a write and a read of the same entry on one edge.
// The map is cleared lazily by frame epochs. After reset, and again each time
// the epoch counter runs out (every 65534 frame starts), a sweep rewrites all
// MAX_SEGMENTS map entries; no header is accepted during it.
// If res is stalled, the finished beat waits in the output register, one more
// header still enters stage 1, and then hdr.ready drops until res drains.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_reassembly_tracker_core #(
	parameter int MAX_SEGMENTS = 1024,
	parameter int HEADER_BYTES = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	srt_hdr_if.sink   hdr,
	srt_res_if.source res,
	srt_cfg_if.sink   cfg
);

	localparam int IW   = $clog2(MAX_SEGMENTS);
	localparam int CW   = $clog2(MAX_SEGMENTS + 1);
	localparam int OW   = IW + 16;
	localparam int SW   = OW + 1;
	localparam int CMPW = (SW > 24) ? SW : 24;
	localparam int EW   = srt_pkg::EPOCH_W;

	logic [15:0]         pps_q;
	logic [23:0]         maxb_q;

	srt_pkg::clr_state_t state_q, state_d;
	logic [IW-1:0]       clr_ptr_q, clr_ptr_d;
	logic                clr_done;
	logic [EW-1:0]       epoch_q, epoch_use;

	logic                accept;
	logic                s1_v_q;
	logic                fwd_s1;
	srt_pkg::front_t     front_s1;
	logic [IW-1:0]       idx_s1;
	logic [CW-1:0]       total_s1;
	logic [OW-1:0]       offset_s1;
	logic [EW-1:0]       rd_tag;

	logic [63:0]         cur_stamp_q;
	logic [CW-1:0]       rcv_q, exp_q;
	logic [23:0]         len_q;
	logic [63:0]         lstamp_q;

	logic                pre_ok, new_frame, roll, entry_set, overflow, take;
	logic                is_last, done, out_free, s1_adv;
	logic [SW-1:0]       sum;
	logic [CMPW-1:0]     sum_ext, off_ext;
	logic [CW-1:0]       rcv_base, rcv_inc, exp_use;
	srt_pkg::verdict_t   verdict_s1;

	logic                mem_we;
	logic [IW-1:0]       mem_waddr;
	logic [EW-1:0]       mem_wdata;

	logic                out_v_q;
	srt_pkg::verdict_t   verdict_q;
	logic [23:0]         woff_q;
	logic                done_q;

	srt_front #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.HEADER_BYTES (HEADER_BYTES),
		.IW           (IW),
		.CW           (CW),
		.OW           (OW)
	) u_front (
		.clk                 (clk),
		.load                (accept),
		.frame_stamp         (hdr.frame_stamp),
		.segment_index       (hdr.segment_index),
		.segment_total       (hdr.segment_total),
		.payload_bytes       (hdr.payload_bytes),
		.datagram_bytes      (hdr.datagram_bytes),
		.payload_per_segment (pps_q),
		.front_s1            (front_s1),
		.idx_s1              (idx_s1),
		.total_s1            (total_s1),
		.offset_s1           (offset_s1)
	);

	srt_map_mem #(
		.DEPTH (MAX_SEGMENTS),
		.AW    (IW),
		.DW    (EW)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (hdr.segment_index[IW-1:0]),
		.rdata (rd_tag)
	);

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pps_q  <= srt_pkg::PAYLOAD_PER_SEGMENT_RESET;
			maxb_q <= srt_pkg::MAX_FRAME_BYTES_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == srt_pkg::REG_PAYLOAD_PER_SEGMENT) begin
				pps_q <= cfg.data[15:0];
			end else if (cfg.index == srt_pkg::REG_MAX_FRAME_BYTES) begin
				maxb_q <= cfg.data[23:0];
			end
		end
	end

	// Stage 1 decision.
	assign pre_ok    = (front_s1.pre == srt_pkg::VERDICT_ACCEPT);
	assign new_frame = (front_s1.stamp != cur_stamp_q);
	assign roll      = s1_v_q && pre_ok && new_frame && (epoch_q == srt_pkg::EPOCH_LAST);
	assign epoch_use = new_frame ? epoch_q + EW'(1) : epoch_q;
	// A new frame sees an empty map; otherwise the entry counts if it carries
	// the live epoch or was written on the edge that issued this read.
	assign entry_set = !new_frame && (fwd_s1 || (rd_tag == epoch_q));

	assign sum      = SW'(offset_s1) + SW'(front_s1.payload);
	assign sum_ext  = CMPW'(sum);
	assign off_ext  = CMPW'(offset_s1);
	assign overflow = (sum_ext > CMPW'(maxb_q));

	always_comb begin
		if (!pre_ok) begin
			verdict_s1 = front_s1.pre;
		end else if (entry_set) begin
			verdict_s1 = srt_pkg::VERDICT_DUP;
		end else if (overflow) begin
			verdict_s1 = srt_pkg::VERDICT_OVERFLOW;
		end else begin
			verdict_s1 = srt_pkg::VERDICT_ACCEPT;
		end
	end

	assign take     = (verdict_s1 == srt_pkg::VERDICT_ACCEPT);
	assign rcv_base = new_frame ? '0 : rcv_q;
	assign rcv_inc  = rcv_base + CW'(1);
	assign exp_use  = new_frame ? total_s1 : exp_q;
	assign is_last  = (total_s1 != '0) && (CW'(idx_s1) == total_s1 - CW'(1));
	assign done     = take && (rcv_inc == exp_use);

	assign out_free  = !out_v_q || res.ready;
	assign s1_adv    = s1_v_q && out_free && (state_q == srt_pkg::CLR_RUN) && !roll;
	assign hdr.ready = (state_q == srt_pkg::CLR_RUN) && (!s1_v_q || s1_adv);
	assign accept    = hdr.valid && hdr.ready;

	// Sweep sequencer and map write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= srt_pkg::CLR_SWEEP;
			clr_ptr_q <= '0;
		end else begin
			state_q   <= state_d;
			clr_ptr_q <= clr_ptr_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		clr_ptr_d = clr_ptr_q;
		clr_done  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = epoch_use;
		case (state_q)
			srt_pkg::CLR_RUN: begin
				mem_we = s1_adv && take;
				if (roll) begin
					state_d   = srt_pkg::CLR_SWEEP;
					clr_ptr_d = '0;
				end
			end
			srt_pkg::CLR_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = clr_ptr_q;
				mem_wdata = srt_pkg::EPOCH_CLEAR;
				if (clr_ptr_q == IW'(MAX_SEGMENTS - 1)) begin
					clr_done = 1'b1;
					state_d  = srt_pkg::CLR_RUN;
				end else begin
					clr_ptr_d = clr_ptr_q + IW'(1);
				end
			end
			default: begin
				state_d = srt_pkg::CLR_SWEEP;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_s1 <= mem_we && (mem_waddr == hdr.segment_index[IW-1:0]);
		end
	end

	// Frame tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q      <= 1'b0;
			epoch_q     <= srt_pkg::EPOCH_FIRST;
			cur_stamp_q <= '0;
			rcv_q       <= '0;
			exp_q       <= '0;
			len_q       <= '0;
			lstamp_q    <= '0;
		end else begin
			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (clr_done) begin
				epoch_q <= srt_pkg::EPOCH_FIRST;
			end else if (s1_adv && pre_ok) begin
				epoch_q <= epoch_use;
			end
			if (s1_adv && pre_ok) begin
				cur_stamp_q <= front_s1.stamp;
				exp_q       <= exp_use;
				rcv_q       <= take ? rcv_inc : rcv_base;
				if (take && is_last) begin
					len_q    <= sum_ext[23:0];
					lstamp_q <= front_s1.stamp;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			verdict_q <= verdict_s1;
			woff_q    <= take ? off_ext[23:0] : 24'd0;
			done_q    <= done;
		end
	end

	// The latched length and stamp only move when the next beat is loaded.
	assign res.valid           = out_v_q;
	assign res.verdict         = verdict_q;
	assign res.write_offset    = woff_q;
	assign res.frame_complete  = done_q;
	assign res.frame_length    = len_q;
	assign res.completed_stamp = lstamp_q;

	`SRT_ASSERT(a_reject_clean, clk, arst_n, res.valid && (res.verdict != srt_pkg::VERDICT_ACCEPT) |-> !res.frame_complete && (res.write_offset == 24'd0))
	`SRT_ASSERT_NEVER(a_sweep_holds_s1, clk, arst_n, (state_q == srt_pkg::CLR_SWEEP) && s1_adv)
	`SRT_ASSERT(a_epoch_restart, clk, arst_n, clr_done |=> (epoch_q == srt_pkg::EPOCH_FIRST))
	`SRT_ASSERT_NEVER(a_count_bound, clk, arst_n, rcv_q > CW'(MAX_SEGMENTS))

endmodule

[verif/segment_reassembly_tracker_core_test.sv]
// ----------------------------------------------------------------------------
// Segment reassembly tracker core testbench
// Walks a short table of datagram headers and register writes, then sends
// randomized frames and noise under several register settings. Every verdict
// beat is predicted from the accepted header and compared field by field.
// ----------------------------------------------------------------------------
module segment_reassembly_tracker_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import srt_pkg::*;

	localparam int MAX_SEGMENTS = 1024;
	localparam int HEADER_BYTES = 20;
	localparam int IDLE_LIMIT = 8000;
	localparam int REPORT_LIMIT = 10;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'hFF;

	typedef enum logic {
		ROW_HEADER = 1'b0,
		ROW_WRITE  = 1'b1
	} row_kind_e;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_BURSTY
	} stall_mode_e;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [23:0] offset;
		logic        done;
		logic [23:0] length;
		logic [63:0] stamp;
	} tracker_beat_t;

	typedef struct {
		row_kind_e                 kind;
		logic [63:0]               stamp;
		logic [31:0]               idx;
		logic [31:0]               total;
		logic [31:0]               pay;
		logic [15:0]               dg;
		logic                      typed;
		tracker_beat_t             want;
		logic [CFG_INDEX_W-1:0]    sel;
		logic [CFG_DATA_W-1:0]     val;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	srt_hdr_if hdr();
	srt_res_if res();
	srt_cfg_if cfg();

	segment_reassembly_tracker_core #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.HEADER_BYTES(HEADER_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.hdr(hdr),
		.res(res),
		.cfg(cfg)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// Tracker state as the predictor sees it.
	logic [15:0] reg_pps = PAYLOAD_PER_SEGMENT_RESET;
	logic [23:0] reg_maxf = MAX_FRAME_BYTES_RESET;
	logic [63:0] trk_stamp = '0;
	int          trk_rcvd = 0;
	int          trk_expected = 0;
	bit          seen_map [MAX_SEGMENTS];
	logic [23:0] held_len = '0;
	logic [63:0] held_stamp = '0;

	tracker_beat_t beats_due[$];
	stim_row_t     plan[$];

	// Typed expectation that travels with the header on the channel.
	logic          row_typed;
	tracker_beat_t row_want;

	int fault_count = 0;
	int idle_cycles = 0;
	int reg_writes = 0;
	int verdict_seen [8];
	int frames_done = 0;

	// Sender bookkeeping.
	bit          hdr_up = 1'b0;
	int          burst_left = 8;
	int          headers_sent = 0;
	logic [15:0] cur_pps = PAYLOAD_PER_SEGMENT_RESET;
	logic [63:0] last_stamp = '0;

	function automatic tracker_beat_t judge_header(input logic [63:0] stamp,
			input logic [31:0] idx, input logic [31:0] total, input logic [31:0] pay,
			input logic [15:0] dg);
		tracker_beat_t b;
		logic [47:0] offset;
		int slot;
		b = '0;
		if (dg < HEADER_BYTES) begin
			b.verdict = VERDICT_SHORT;
		end else if (64'(pay) + 64'(HEADER_BYTES) != 64'(dg)) begin
			b.verdict = VERDICT_LENGTH;
		end else if (idx >= MAX_SEGMENTS) begin
			b.verdict = VERDICT_INDEX;
		end else if (total > MAX_SEGMENTS) begin
			b.verdict = VERDICT_COUNT;
		end else begin
			// A new stamp restarts the frame even if the segment is refused below.
			if (trk_stamp != stamp) begin
				trk_stamp = stamp;
				trk_rcvd = 0;
				trk_expected = int'(total);
				foreach (seen_map[i]) seen_map[i] = 1'b0;
			end
			slot = int'(idx);
			if (seen_map[slot]) begin
				b.verdict = VERDICT_DUP;
			end else begin
				offset = 48'(idx) * 48'(reg_pps);
				if (offset + 48'(pay) > 48'(reg_maxf)) begin
					b.verdict = VERDICT_OVERFLOW;
				end else begin
					seen_map[slot] = 1'b1;
					trk_rcvd++;
					if (total != 0 && idx == total - 1) begin
						held_len = 24'(offset + 48'(pay));
						held_stamp = stamp;
					end
					b.verdict = VERDICT_ACCEPT;
					b.offset = offset[23:0];
					b.done = (trk_rcvd == trk_expected);
				end
			end
		end
		b.length = held_len;
		b.stamp = held_stamp;
		return b;
	endfunction

	task automatic note_fault(input string what, input tracker_beat_t want,
			input tracker_beat_t got);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("%0t %s (expected/actual): verdict %0d/%0d offset %0d/%0d complete %0d/%0d",
				$realtime, what, want.verdict, got.verdict, want.offset, got.offset,
				want.done, got.done);
			$display("    length %0d/%0d stamp %h/%h", want.length, got.length,
				want.stamp, got.stamp);
		end
	endtask

	// Predictor, checker and watchdog, all sampling pre-edge values.
	always @(posedge clk) begin
		tracker_beat_t got;
		tracker_beat_t want;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				reg_writes++;
				if (cfg.index == REG_PAYLOAD_PER_SEGMENT) begin
					reg_pps = cfg.data[15:0];
				end else if (cfg.index == REG_MAX_FRAME_BYTES) begin
					reg_maxf = cfg.data[23:0];
				end
			end
			if (hdr.valid && hdr.ready) begin
				want = judge_header(hdr.frame_stamp, hdr.segment_index, hdr.segment_total,
					hdr.payload_bytes, hdr.datagram_bytes);
				if (row_typed) want = row_want;
				beats_due.push_back(want);
			end
			if (res.valid && res.ready) begin
				got.verdict = res.verdict;
				got.offset = res.write_offset;
				got.done = res.frame_complete;
				got.length = res.frame_length;
				got.stamp = res.completed_stamp;
				verdict_seen[got.verdict]++;
				if (got.done) frames_done++;
				if (beats_due.size() == 0) begin
					note_fault("result beat with nothing pending", '0, got);
				end else begin
					want = beats_due.pop_front();
					if (got !== want) note_fault("result mismatch", want, got);
				end
			end
			if ((hdr.valid && hdr.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles, %0d results pending",
					idle_cycles, beats_due.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// The result side stalls in modes that change at random intervals.
	initial begin
		stall_mode_e mode;
		int mode_left;
		int stall_left;
		int tick;
		logic rdy;
		mode = STALL_NONE;
		mode_left = 0;
		stall_left = 0;
		tick = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = stall_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			tick++;
			case (mode)
				STALL_NONE: begin
					rdy = 1'b1;
				end
				STALL_RANDOM: begin
					rdy = ($urandom_range(0, 3) != 0);
				end
				STALL_PERIODIC: begin
					rdy = (tick % 7) >= 2;
				end
				default: begin
					if (stall_left > 0) begin
						rdy = 1'b0;
						stall_left--;
					end else begin
						rdy = 1'b1;
						if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 24);
					end
				end
			endcase
			res.ready <= rdy;
		end
	end

	function automatic stim_row_t hdr_row(input logic [63:0] stamp, input logic [31:0] idx,
			input logic [31:0] total, input logic [31:0] pay, input logic [15:0] dg);
		stim_row_t r;
		r.kind = ROW_HEADER;
		r.stamp = stamp;
		r.idx = idx;
		r.total = total;
		r.pay = pay;
		r.dg = dg;
		r.typed = 1'b0;
		r.want = '0;
		r.sel = '0;
		r.val = '0;
		return r;
	endfunction

	function automatic stim_row_t with_beat(input stim_row_t r, input logic [2:0] verdict,
			input logic [23:0] offset, input logic done, input logic [23:0] length,
			input logic [63:0] stamp);
		stim_row_t t;
		t = r;
		t.typed = 1'b1;
		t.want = '{verdict, offset, done, length, stamp};
		return t;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_INDEX_W-1:0] sel,
			input logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = hdr_row('0, '0, '0, '0, '0);
		r.kind = ROW_WRITE;
		r.sel = sel;
		r.val = val;
		return r;
	endfunction

	function automatic void build_plan();
		// Rejections first: nothing moves, so the latched fields stay at reset.
		plan.push_back(with_beat(hdr_row(64'd0, 32'd0, 32'd0, 32'd0, 16'd0),
			VERDICT_SHORT, 24'd0, 1'b0, 24'd0, 64'd0));
		plan.push_back(with_beat(hdr_row('1, '1, '1, '1, 16'd19),
			VERDICT_SHORT, 24'd0, 1'b0, 24'd0, 64'd0));
		plan.push_back(with_beat(hdr_row(64'd1, 32'd0, 32'd1, 32'd1, 16'd20),
			VERDICT_LENGTH, 24'd0, 1'b0, 24'd0, 64'd0));
		plan.push_back(with_beat(hdr_row(64'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, 16'hFFFF),
			VERDICT_LENGTH, 24'd0, 1'b0, 24'd0, 64'd0));
		plan.push_back(with_beat(hdr_row(64'd0, 32'd1024, 32'd1, 32'd65515, 16'hFFFF),
			VERDICT_INDEX, 24'd0, 1'b0, 24'd0, 64'd0));
		plan.push_back(with_beat(hdr_row('1, 32'hFFFF_FFFF, 32'd1, 32'd0, 16'd20),
			VERDICT_INDEX, 24'd0, 1'b0, 24'd0, 64'd0));
		plan.push_back(with_beat(hdr_row(64'd0, 32'd0, 32'd1025, 32'd0, 16'd20),
			VERDICT_COUNT, 24'd0, 1'b0, 24'd0, 64'd0));
		plan.push_back(with_beat(hdr_row(64'd0, 32'd1023, 32'hFFFF_FFFF, 32'd0, 16'd20),
			VERDICT_COUNT, 24'd0, 1'b0, 24'd0, 64'd0));
		// Stamp zero matches the reset stamp, so the expected count stays zero.
		plan.push_back(with_beat(hdr_row(64'd0, 32'd3, 32'd4, 32'd100, 16'd120),
			VERDICT_ACCEPT, 24'd4200, 1'b0, 24'd4300, 64'd0));
		plan.push_back(with_beat(hdr_row(64'd0, 32'd3, 32'd4, 32'd100, 16'd120),
			VERDICT_DUP, 24'd0, 1'b0, 24'd4300, 64'd0));
		plan.push_back(with_beat(hdr_row(64'd0, 32'd0, 32'd4, 32'd1400, 16'd1420),
			VERDICT_ACCEPT, 24'd0, 1'b0, 24'd4300, 64'd0));
		plan.push_back(hdr_row(64'd5, 32'd0, 32'd2, 32'd1400, 16'd1420));
		plan.push_back(hdr_row(64'd5, 32'd1, 32'd2, 32'd1000, 16'd1020));
		plan.push_back(hdr_row(64'd5, 32'd1, 32'd2, 32'd1000, 16'd1020));
		// Refused on overflow, yet the new stamp still opens a new frame.
		plan.push_back(with_beat(hdr_row(64'd6, 32'd1023, 32'd1024, 32'd0, 16'd20),
			VERDICT_OVERFLOW, 24'd0, 1'b0, 24'd2400, 64'd5));
		plan.push_back(hdr_row(64'd6, 32'd748, 32'd1024, 32'd1377, 16'd1397));
		plan.push_back(hdr_row(64'd6, 32'd748, 32'd1024, 32'd1376, 16'd1396));
		plan.push_back(hdr_row(64'd7, 32'd0, 32'd1, 32'd65515, 16'hFFFF));
		plan.push_back(hdr_row(64'd8, 32'd2, 32'd0, 32'd10, 16'd30));
		plan.push_back(hdr_row(64'd8, 32'd3, 32'd0, 32'd0, 16'd20));
		// Upper data bits beyond each register's width are dropped.
		plan.push_back(reg_row(REG_PAYLOAD_PER_SEGMENT, 32'hFFFF_0000));
		plan.push_back(reg_row(REG_MAX_FRAME_BYTES, 32'hFFFF_FFFF));
		plan.push_back(reg_row(REG_UNUSED, 32'h1234_5678));
		plan.push_back(hdr_row(64'd9, 32'd1023, 32'd1024, 32'd500, 16'd520));
		plan.push_back(hdr_row(64'd9, 32'd5, 32'd1024, 32'd0, 16'd20));
		plan.push_back(reg_row(REG_PAYLOAD_PER_SEGMENT, 32'd65515));
		plan.push_back(hdr_row(64'd10, 32'd256, 32'd257, 32'd65515, 16'hFFFF));
		plan.push_back(hdr_row(64'd10, 32'd255, 32'd257, 32'd65515, 16'hFFFF));
	endfunction

	task automatic drop_valid();
		if (hdr_up) begin
			hdr.valid <= 1'b0;
			hdr_up = 1'b0;
		end
	endtask

	// Wait until every verdict beat is back, plus a margin for the pipeline.
	task automatic settle();
		drop_valid();
		do @(posedge clk); while (beats_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
		cfg.index <= sel;
		cfg.data <= val;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (sel == REG_PAYLOAD_PER_SEGMENT) cur_pps = val[15:0];
		@(posedge clk);
	endtask

	task automatic send_header(input logic [63:0] stamp, input logic [31:0] idx,
			input logic [31:0] total, input logic [31:0] pay, input logic [15:0] dg,
			input logic typed, input tracker_beat_t want);
		int gap;
		hdr.frame_stamp <= stamp;
		hdr.segment_index <= idx;
		hdr.segment_total <= total;
		hdr.payload_bytes <= pay;
		hdr.datagram_bytes <= dg;
		row_typed <= typed;
		row_want <= want;
		if (!hdr_up) begin
			hdr.valid <= 1'b1;
			hdr_up = 1'b1;
		end
		do @(posedge clk); while (!hdr.ready);
		headers_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
			if (gap > 0) begin
				drop_valid();
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_noise();
		logic [63:0] stamp;
		logic [31:0] idx;
		logic [31:0] total;
		logic [31:0] pay;
		logic [15:0] dg;
		stamp = $urandom_range(0, 1) ? {$urandom, $urandom} : last_stamp;
		idx = $urandom;
		total = $urandom;
		pay = $urandom;
		dg = 16'($urandom_range(0, 65535));
		// Half the noise has a consistent length so it reaches the later checks.
		if ($urandom_range(0, 1)) begin
			pay = $urandom_range(0, 65515);
			dg = 16'(pay + HEADER_BYTES);
			idx = $urandom_range(0, 2047);
			total = $urandom_range(0, 2048);
		end
		send_header(stamp, idx, total, pay, dg, 1'b0, '0);
	endtask

	// One frame of segments in shuffled order, with an occasional flaw.
	task automatic send_frame();
		logic [63:0] stamp;
		logic [31:0] idx;
		logic [31:0] hdr_total;
		logic [31:0] pay;
		logic [15:0] dg;
		int total;
		int cap;
		int flaw;
		int k;
		int tmp;
		int order[$];
		case ($urandom_range(0, 19))
			0: stamp = 64'd0;
			1: stamp = '1;
			2: stamp = last_stamp;
			default: stamp = {$urandom, $urandom};
		endcase
		tmp = $urandom_range(0, 99);
		if (tmp < 6) total = 0;
		else if (tmp < 12) total = $urandom_range(13, MAX_SEGMENTS);
		else total = $urandom_range(1, 12);
		if (total >= 1 && total <= 12) begin
			for (int j = 0; j < total; j++) order.push_back(j);
		end else begin
			tmp = $urandom_range(1, 8);
			for (int j = 0; j < tmp; j++) order.push_back($urandom_range(0, total == 0 ? 31 : total - 1));
			if (total > 0 && $urandom_range(0, 1)) order.push_back(total - 1);
		end
		for (int j = order.size() - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			tmp = order[j];
			order[j] = order[k];
			order[k] = tmp;
		end
		cap = (cur_pps == 0) ? 1500 : ((cur_pps > 65515) ? 65515 : int'(cur_pps));
		for (int j = 0; j < order.size(); j++) begin
			idx = order[j];
			hdr_total = total;
			pay = ($urandom_range(0, 3) == 0) ? cap : $urandom_range(0, cap);
			dg = 16'(pay + HEADER_BYTES);
			flaw = $urandom_range(0, 99);
			if (flaw < 4) dg = (dg == 16'hFFFF) ? dg - 16'd1 : dg + 16'd1;
			else if (flaw < 7) idx = MAX_SEGMENTS + $urandom_range(0, 100);
			else if (flaw < 9) hdr_total = MAX_SEGMENTS + 1 + $urandom_range(0, 50);
			else if (flaw < 14 && j > 0) idx = order[j - 1];
			send_header(stamp, idx, hdr_total, pay, dg, 1'b0, '0);
			// A stamp change in mid-frame abandons the rest of it.
			if ($urandom_range(0, 49) == 0) stamp = {$urandom, $urandom};
		end
		last_stamp = stamp;
	endtask

	task automatic run_phase(input logic [15:0] pps, input logic [23:0] maxf, input int quota);
		int start;
		settle();
		write_reg(REG_PAYLOAD_PER_SEGMENT, {16'($urandom), pps});
		write_reg(REG_MAX_FRAME_BYTES, {8'($urandom), maxf});
		start = headers_sent;
		while (headers_sent - start < quota) begin
			if ($urandom_range(0, 7) == 0) send_noise();
			else send_frame();
			if ($urandom_range(0, 29) == 0) settle();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		hdr.valid <= 1'b0;
		hdr.frame_stamp <= '0;
		hdr.segment_index <= '0;
		hdr.segment_total <= '0;
		hdr.payload_bytes <= '0;
		hdr.datagram_bytes <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		row_typed <= 1'b0;
		row_want <= '0;
		build_plan();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < plan.size(); r++) begin
			if (plan[r].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[r].sel, plan[r].val);
			end else begin
				send_header(plan[r].stamp, plan[r].idx, plan[r].total, plan[r].pay, plan[r].dg,
					plan[r].typed, plan[r].want);
			end
		end

		run_phase(PAYLOAD_PER_SEGMENT_RESET, MAX_FRAME_BYTES_RESET, 250);
		run_phase(16'd65515, 24'hFF_FFFF, 200);
		run_phase(16'd0, 24'hFF_FFFF, 150);
		run_phase(16'd1, 24'd1, 100);
		run_phase(16'($urandom_range(1, 2000)), 24'($urandom_range(1, 1 << 20)), 250);
		run_phase(16'd512, 24'd8192, 200);
		run_phase(16'($urandom_range(1, 65515)), 24'($urandom_range(1, 24'hFF_FFFF)), 250);
		settle();

		$display("Sent %0d headers and %0d register writes; %0d frames flagged complete.",
			headers_sent, reg_writes, frames_done);
		$display("Verdicts: accept %0d, short %0d, length %0d, index %0d, count %0d, dup %0d, overflow %0d.",
			verdict_seen[VERDICT_ACCEPT], verdict_seen[VERDICT_SHORT], verdict_seen[VERDICT_LENGTH],
			verdict_seen[VERDICT_INDEX], verdict_seen[VERDICT_COUNT], verdict_seen[VERDICT_DUP],
			verdict_seen[VERDICT_OVERFLOW]);
		if (fault_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d result faults", fault_count);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/srt_pkg.sv
rtl/srt_if.sv
rtl/srt_map_mem.sv
rtl/srt_front.sv
rtl/segment_reassembly_tracker_core.sv
verif/segment_reassembly_tracker_core_test.sv
